>>> src/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg: types and codes of the sampler actuator sequencer
// Item layouts, sequencer state, configuration set and the command, response,
// mode and step codes shared by the pass logic and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sas_pkg;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_ECHO     = 3'd1,
    CMD_QUERY    = 3'd2,
    CMD_SAMPLE   = 3'd3,
    CMD_DISCHG   = 3'd4,
    CMD_ARM      = 3'd5,
    CMD_UNKNOWN  = 3'd6,
    CMD_RESERVED = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    RSP_NONE        = 4'd0,
    RSP_ACK         = 4'd1,
    RSP_INIT        = 4'd2,
    RSP_FINAL       = 4'd3,
    RSP_SAMPLE_OK   = 4'd4,
    RSP_SAMPLE_DONE = 4'd5,
    RSP_DISCHG_OK   = 4'd6,
    RSP_ARMED_OK    = 4'd7,
    RSP_SENSOR      = 4'd8
  } rsp_t;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_SAMPLING = 2'd1,
    MODE_DISCHG   = 2'd2,
    MODE_ARMING   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    MOTOR_HALT = 2'd0,
    MOTOR_DOWN = 2'd1,
    MOTOR_UP   = 2'd2
  } motor_t;

  typedef enum logic [2:0] {
    SS_CONFIRM    = 3'd0,
    SS_DOWN       = 3'd1,
    SS_WAIT_FINAL = 3'd2,
    SS_TAKE       = 3'd3,
    SS_DONE       = 3'd4
  } sstep_t;

  typedef enum logic [1:0] {
    AS_UP        = 2'd0,
    AS_WAIT_INIT = 2'd1,
    AS_CONFIRM   = 2'd2
  } astep_t;

  // configuration register indexes
  localparam logic [1:0] CFG_MOTOR_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_VALVE_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_DISCHG_TIME   = 2'd2;
  localparam logic [1:0] CFG_DISCHG_WINDOW = 2'd3;

  localparam logic [15:0] MOTOR_TIMEOUT_RST = 16'd15000;
  localparam logic [15:0] VALVE_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] DISCHG_TIME_RST   = 16'd10000;
  localparam logic [7:0]  DISCHG_WINDOW_RST = 8'd10;

  localparam logic [15:0] ELAPSED_MAX = 16'hffff;

  typedef struct packed {
    logic [2:0] command;
    logic       tick_elapsed;
    logic       initial_switch;
    logic       final_switch;
    logic       sensor_line;
  } in_t;

  typedef struct packed {
    logic [3:0] response;
    logic [1:0] motor_drive;
    logic       valve_open;
    logic [1:0] mode;
  } out_t;

  typedef struct packed {
    logic [15:0] motor_timeout_ms;
    logic [15:0] valve_timeout_ms;
    logic [15:0] discharge_time_ms;
    logic [7:0]  discharge_open_window_ms;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    sstep_t      sstep;
    astep_t      astep;
    logic [15:0] elapsed;
    motor_t      motor;
    logic        valve;
    logic        pending;
  } state_t;

endpackage

`default_nettype wire

>>> src/sas_pass.sv
// ----------------------------------------------------------------------------
// sas_pass: one polling pass of the sequencer
// Combinational next state and result item for one input item.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_pass (
  input  sas_pkg::state_t st,
  input  sas_pkg::cfg_t   cfg,
  input  sas_pkg::in_t    item,
  output sas_pkg::state_t st_next,
  output sas_pkg::out_t   result
);

  logic [15:0]    elapsed_inc;
  logic           pending_in;
  logic           is_query;
  logic           in_window;
  logic           dischg_over;
  logic           motor_expired;
  logic           valve_expired;
  sas_pkg::cmd_t  cmd;
  sas_pkg::rsp_t  rsp;

  assign cmd = sas_pkg::cmd_t'(item.command);

  // counter and pending flag are updated before the command is looked at
  assign elapsed_inc = (item.tick_elapsed && st.elapsed != sas_pkg::ELAPSED_MAX) ?
                       st.elapsed + 16'd1 : st.elapsed;
  assign pending_in  = st.pending | item.sensor_line;
  assign is_query    = (cmd == sas_pkg::CMD_ECHO) || (cmd == sas_pkg::CMD_QUERY);

  assign in_window     = elapsed_inc < {8'd0, cfg.discharge_open_window_ms};
  assign dischg_over   = elapsed_inc >= cfg.discharge_time_ms;
  assign motor_expired = elapsed_inc >= cfg.motor_timeout_ms;
  assign valve_expired = elapsed_inc >= cfg.valve_timeout_ms;

  // next state
  always_comb begin
    st_next         = st;
    st_next.elapsed = elapsed_inc;
    st_next.pending = pending_in;
    if (!is_query) begin
      unique case (st.mode)
        sas_pkg::MODE_IDLE: begin
          if (cmd == sas_pkg::CMD_SAMPLE || cmd == sas_pkg::CMD_DISCHG ||
              cmd == sas_pkg::CMD_ARM) begin
            st_next.mode    = (cmd == sas_pkg::CMD_SAMPLE) ? sas_pkg::MODE_SAMPLING :
                              (cmd == sas_pkg::CMD_DISCHG) ? sas_pkg::MODE_DISCHG :
                                                             sas_pkg::MODE_ARMING;
            st_next.sstep   = sas_pkg::SS_CONFIRM;
            st_next.astep   = sas_pkg::AS_UP;
            st_next.elapsed = 16'd0;
          end
          st_next.pending = 1'b0;
        end
        sas_pkg::MODE_SAMPLING: begin
          unique case (st.sstep)
            sas_pkg::SS_CONFIRM: begin
              st_next.sstep   = sas_pkg::SS_DOWN;
              st_next.elapsed = 16'd0;
            end
            sas_pkg::SS_DOWN: begin
              st_next.motor   = sas_pkg::MOTOR_DOWN;
              st_next.sstep   = sas_pkg::SS_WAIT_FINAL;
              st_next.elapsed = 16'd0;
            end
            sas_pkg::SS_WAIT_FINAL: begin
              if (item.final_switch) begin
                // a line that came in during the descent is stale
                st_next.motor   = sas_pkg::MOTOR_HALT;
                st_next.valve   = 1'b1;
                st_next.pending = 1'b0;
                st_next.sstep   = sas_pkg::SS_TAKE;
                st_next.elapsed = 16'd0;
              end else if (motor_expired) begin
                st_next.motor   = sas_pkg::MOTOR_HALT;
                st_next.valve   = 1'b0;
                st_next.mode    = sas_pkg::MODE_IDLE;
                st_next.sstep   = sas_pkg::SS_CONFIRM;
                st_next.astep   = sas_pkg::AS_UP;
                st_next.elapsed = 16'd0;
              end
            end
            sas_pkg::SS_TAKE: begin
              if (pending_in || valve_expired) begin
                st_next.pending = 1'b0;
                st_next.valve   = 1'b0;
                st_next.sstep   = sas_pkg::SS_DONE;
                st_next.elapsed = 16'd0;
              end
            end
            sas_pkg::SS_DONE: begin
              st_next.mode    = sas_pkg::MODE_IDLE;
              st_next.sstep   = sas_pkg::SS_CONFIRM;
              st_next.astep   = sas_pkg::AS_UP;
              st_next.elapsed = 16'd0;
            end
            default: begin
              st_next.motor   = sas_pkg::MOTOR_HALT;
              st_next.valve   = 1'b0;
              st_next.mode    = sas_pkg::MODE_IDLE;
              st_next.sstep   = sas_pkg::SS_CONFIRM;
              st_next.astep   = sas_pkg::AS_UP;
              st_next.elapsed = 16'd0;
            end
          endcase
        end
        sas_pkg::MODE_DISCHG: begin
          if (in_window) begin
            st_next.valve = 1'b1;
          end else if (dischg_over) begin
            st_next.valve   = 1'b0;
            st_next.mode    = sas_pkg::MODE_IDLE;
            st_next.sstep   = sas_pkg::SS_CONFIRM;
            st_next.astep   = sas_pkg::AS_UP;
            st_next.elapsed = 16'd0;
          end
        end
        default: begin
          unique case (st.astep)
            sas_pkg::AS_UP: begin
              st_next.motor   = sas_pkg::MOTOR_UP;
              st_next.astep   = sas_pkg::AS_WAIT_INIT;
              st_next.elapsed = 16'd0;
            end
            sas_pkg::AS_WAIT_INIT: begin
              if (item.initial_switch) begin
                st_next.motor   = sas_pkg::MOTOR_HALT;
                st_next.astep   = sas_pkg::AS_CONFIRM;
                st_next.elapsed = 16'd0;
              end else if (motor_expired) begin
                st_next.motor   = sas_pkg::MOTOR_HALT;
                st_next.valve   = 1'b0;
                st_next.mode    = sas_pkg::MODE_IDLE;
                st_next.sstep   = sas_pkg::SS_CONFIRM;
                st_next.astep   = sas_pkg::AS_UP;
                st_next.elapsed = 16'd0;
              end
            end
            sas_pkg::AS_CONFIRM: begin
              st_next.mode    = sas_pkg::MODE_IDLE;
              st_next.sstep   = sas_pkg::SS_CONFIRM;
              st_next.astep   = sas_pkg::AS_UP;
              st_next.elapsed = 16'd0;
            end
            default: begin
              st_next.motor   = sas_pkg::MOTOR_HALT;
              st_next.valve   = 1'b0;
              st_next.mode    = sas_pkg::MODE_IDLE;
              st_next.sstep   = sas_pkg::SS_CONFIRM;
              st_next.astep   = sas_pkg::AS_UP;
              st_next.elapsed = 16'd0;
            end
          endcase
        end
      endcase
    end
  end

  // response of the pass
  always_comb begin
    rsp = sas_pkg::RSP_NONE;
    if (cmd == sas_pkg::CMD_ECHO) begin
      rsp = sas_pkg::RSP_ACK;
    end else if (cmd == sas_pkg::CMD_QUERY) begin
      rsp = item.initial_switch ? sas_pkg::RSP_INIT : sas_pkg::RSP_FINAL;
    end else begin
      unique case (st.mode)
        sas_pkg::MODE_IDLE: begin
          if (pending_in) rsp = sas_pkg::RSP_SENSOR;
        end
        sas_pkg::MODE_SAMPLING: begin
          if (st.sstep == sas_pkg::SS_CONFIRM) begin
            rsp = sas_pkg::RSP_SAMPLE_OK;
          end else if (st.sstep == sas_pkg::SS_TAKE && pending_in) begin
            rsp = sas_pkg::RSP_SENSOR;
          end else if (st.sstep == sas_pkg::SS_DONE) begin
            rsp = sas_pkg::RSP_SAMPLE_DONE;
          end
        end
        sas_pkg::MODE_DISCHG: begin
          if (!in_window && dischg_over) rsp = sas_pkg::RSP_DISCHG_OK;
        end
        default: begin
          if (st.astep == sas_pkg::AS_CONFIRM) rsp = sas_pkg::RSP_ARMED_OK;
        end
      endcase
    end
  end

  always_comb begin
    result.response    = rsp;
    result.motor_drive = st_next.motor;
    result.valve_open  = st_next.valve;
    result.mode        = st_next.mode;
  end

endmodule

`default_nettype wire

>>> src/sampler_actuator_sequencer_unit.sv
// ----------------------------------------------------------------------------
// sampler_actuator_sequencer_unit: rod motor and valve sequencer
// Each input item is one polling pass; each pass yields exactly one result item
// with the response code and the motor, valve and mode after the pass.
//
// Channels: in_valid/in_stall/in_data carries passes, out_valid/out_stall/
// out_data carries results. An item moves when valid is high and stall low.
// cfg_valid/cfg_ready/cfg_index/cfg_data writes the four timing registers;
// cfg_ready is always high. Write them only while no pass is in flight.
//
// An accepted item goes into the input register, then through the pass logic
// into the result register. Throughput: one item per cycle while out_stall does
// not hold the result register full; the state update is a single pass of
// logic on the input register.
// When out_stall holds the result register full, the input register is held
// and in_stall rises; at most one item waits there.
// Reset (rst, synchronous): idle mode, motor stopped, valve closed, counter and
// pending sensor flag cleared, registers back to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module sampler_actuator_sequencer_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  sas_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output sas_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  sas_pkg::in_t    in_q;
  logic            in_q_valid;
  sas_pkg::state_t st;
  sas_pkg::state_t st_next;
  sas_pkg::cfg_t   cfg;
  sas_pkg::out_t   result;
  logic            advance;

  assign cfg_ready = 1'b1;

  assign advance  = in_q_valid && !(out_valid && out_stall);
  assign in_stall = in_q_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.motor_timeout_ms         <= sas_pkg::MOTOR_TIMEOUT_RST;
      cfg.valve_timeout_ms         <= sas_pkg::VALVE_TIMEOUT_RST;
      cfg.discharge_time_ms        <= sas_pkg::DISCHG_TIME_RST;
      cfg.discharge_open_window_ms <= sas_pkg::DISCHG_WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sas_pkg::CFG_MOTOR_TIMEOUT: cfg.motor_timeout_ms         <= cfg_data;
        sas_pkg::CFG_VALVE_TIMEOUT: cfg.valve_timeout_ms         <= cfg_data;
        sas_pkg::CFG_DISCHG_TIME:   cfg.discharge_time_ms        <= cfg_data;
        sas_pkg::CFG_DISCHG_WINDOW: cfg.discharge_open_window_ms <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q <= in_data;
    end
  end

  sas_pass u_pass (
    .st      (st),
    .cfg     (cfg),
    .item    (in_q),
    .st_next (st_next),
    .result  (result)
  );

  // sequencer state, committed once per pass
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode    <= sas_pkg::MODE_IDLE;
      st.sstep   <= sas_pkg::SS_CONFIRM;
      st.astep   <= sas_pkg::AS_UP;
      st.elapsed <= 16'd0;
      st.motor   <= sas_pkg::MOTOR_HALT;
      st.valve   <= 1'b0;
      st.pending <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // idle always means motor stopped and valve shut
  a_idle_safe: assert property (@(posedge clk) disable iff (rst)
    st.mode == sas_pkg::MODE_IDLE |-> (!st.valve && st.motor == sas_pkg::MOTOR_HALT))
    else $error("idle with motor or valve driven");

  a_query_holds_mode: assert property (@(posedge clk) disable iff (rst)
    (advance && (in_q.command == sas_pkg::CMD_ECHO ||
                 in_q.command == sas_pkg::CMD_QUERY))
    |=> st.mode == $past(st.mode))
    else $error("ping or status changed the mode");

  a_pass_shows_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> (out_valid && out_data.mode == st.mode))
    else $error("pass did not load the result register");

  a_sstep_legal: assert property (@(posedge clk) disable iff (rst)
    st.mode == sas_pkg::MODE_SAMPLING |-> st.sstep <= sas_pkg::SS_DONE)
    else $error("sampling step out of range");

endmodule

`default_nettype wire

>>> verif/sampler_actuator_sequencer_unit_test.sv
// ----------------------------------------------------------------------------
// sampler_actuator_sequencer_unit_test: pass-by-pass check of the sequencer
// A queue-fed driver offers polling passes and a monitor takes the results.
// An in-bench model of the rod and valve sequencer predicts every result.
// Directed passes come first, then random command sequences under several
// timing settings with random gaps on both sides.
// ----------------------------------------------------------------------------
module sampler_actuator_sequencer_unit_test;
  import sas_pkg::*;

  localparam int unsigned LIMIT = 1_000_000;
  localparam int LONG_HOLD = 200;
  localparam int REPORT_MAX = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_MOTOR_TIMEOUT;
  logic [15:0] cfg_data = '0;

  sampler_actuator_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  in_t         pending_passes[$];
  out_t        predicted_results[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int unsigned cycles = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int          long_hold_req = 0;
  int          long_hold_seen = 0;
  int          tx_wait = 0;
  int          rx_wait = 0;

  // model of the sequencer
  mode_t       seq_mode;
  sstep_t      samp_step;
  astep_t      arm_step;
  logic [15:0] step_ms;
  motor_t      motor_now;
  logic        valve_now;
  logic        line_waiting;
  logic [15:0] motor_limit_ms;
  logic [15:0] valve_limit_ms;
  logic [15:0] flush_ms;
  logic [7:0]  flush_window_ms;

  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  task automatic begin_mode(input mode_t m);
    seq_mode  = m;
    samp_step = SS_CONFIRM;
    arm_step  = AS_UP;
    step_ms   = '0;
  endtask

  task automatic halt_to_idle();
    motor_now = MOTOR_HALT;
    valve_now = 1'b0;
    begin_mode(MODE_IDLE);
  endtask

  task automatic poll_pass(input in_t p, output out_t r);
    rsp_t rsp;
    cmd_t cmd;
    rsp = RSP_NONE;
    cmd = cmd_t'(p.command);
    if (p.tick_elapsed && step_ms != ELAPSED_MAX) step_ms = step_ms + 16'd1;
    if (p.sensor_line) line_waiting = 1'b1;
    // ping and status answer at once and freeze the sequence for this pass
    if (cmd == CMD_ECHO) begin
      rsp = RSP_ACK;
    end else if (cmd == CMD_QUERY) begin
      if (p.initial_switch) rsp = RSP_INIT;
      else rsp = RSP_FINAL;
    end else begin
      case (seq_mode)
        MODE_IDLE: begin
          case (cmd)
            CMD_SAMPLE: begin_mode(MODE_SAMPLING);
            CMD_DISCHG: begin_mode(MODE_DISCHG);
            CMD_ARM:    begin_mode(MODE_ARMING);
            default: ;
          endcase
          if (line_waiting) begin
            line_waiting = 1'b0;
            rsp = RSP_SENSOR;
          end
        end
        MODE_SAMPLING: begin
          case (samp_step)
            SS_CONFIRM: begin
              rsp = RSP_SAMPLE_OK;
              samp_step = SS_DOWN;
              step_ms = '0;
            end
            SS_DOWN: begin
              motor_now = MOTOR_DOWN;
              samp_step = SS_WAIT_FINAL;
              step_ms = '0;
            end
            SS_WAIT_FINAL: begin
              if (p.final_switch) begin
                motor_now = MOTOR_HALT;
                valve_now = 1'b1;
                line_waiting = 1'b0;
                samp_step = SS_TAKE;
                step_ms = '0;
              end else if (step_ms >= motor_limit_ms) begin
                halt_to_idle();
              end
            end
            SS_TAKE: begin
              if (line_waiting) begin
                line_waiting = 1'b0;
                rsp = RSP_SENSOR;
                valve_now = 1'b0;
                samp_step = SS_DONE;
                step_ms = '0;
              end else if (step_ms >= valve_limit_ms) begin
                valve_now = 1'b0;
                samp_step = SS_DONE;
                step_ms = '0;
              end
            end
            SS_DONE: begin
              rsp = RSP_SAMPLE_DONE;
              begin_mode(MODE_IDLE);
            end
            default: halt_to_idle();
          endcase
        end
        MODE_DISCHG: begin
          if (step_ms < {8'd0, flush_window_ms}) begin
            valve_now = 1'b1;
          end else if (step_ms >= flush_ms) begin
            valve_now = 1'b0;
            rsp = RSP_DISCHG_OK;
            begin_mode(MODE_IDLE);
          end
        end
        default: begin
          case (arm_step)
            AS_UP: begin
              motor_now = MOTOR_UP;
              arm_step = AS_WAIT_INIT;
              step_ms = '0;
            end
            AS_WAIT_INIT: begin
              if (p.initial_switch) begin
                motor_now = MOTOR_HALT;
                arm_step = AS_CONFIRM;
                step_ms = '0;
              end else if (step_ms >= motor_limit_ms) begin
                halt_to_idle();
              end
            end
            AS_CONFIRM: begin
              rsp = RSP_ARMED_OK;
              begin_mode(MODE_IDLE);
            end
            default: halt_to_idle();
          endcase
        end
      endcase
    end
    r.response    = rsp;
    r.motor_drive = motor_now;
    r.valve_open  = valve_now;
    r.mode        = seq_mode;
  endtask

  // driver: feeds passes, tracks register writes, predicts on acceptance
  always @(posedge clk) begin : driver
    out_t predicted;
    if (rst) begin
      in_valid        <= 1'b0;
      tx_wait         = 0;
      seq_mode        = MODE_IDLE;
      samp_step       = SS_CONFIRM;
      arm_step        = AS_UP;
      step_ms         = '0;
      motor_now       = MOTOR_HALT;
      valve_now       = 1'b0;
      line_waiting    = 1'b0;
      motor_limit_ms  = MOTOR_TIMEOUT_RST;
      valve_limit_ms  = VALVE_TIMEOUT_RST;
      flush_ms        = DISCHG_TIME_RST;
      flush_window_ms = DISCHG_WINDOW_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MOTOR_TIMEOUT: motor_limit_ms = cfg_data;
          CFG_VALVE_TIMEOUT: valve_limit_ms = cfg_data;
          CFG_DISCHG_TIME:   flush_ms = cfg_data;
          CFG_DISCHG_WINDOW: flush_window_ms = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        poll_pass(in_data, predicted);
        predicted_results.push_back(predicted);
      end
      if (!in_valid || !in_stall) begin
        if (tx_wait != 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending_passes.size() != 0) begin
          in_data  <= pending_passes.pop_front();
          in_valid <= 1'b1;
          tx_wait = (tx_idle_en && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rx_wait = 0;
      out_stall <= 1'b0;
    end else begin
      if (long_hold_seen != long_hold_req) begin
        long_hold_seen = long_hold_req;
        rx_wait = LONG_HOLD;
      end else if (rx_wait != 0) begin
        rx_wait--;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        rx_wait = gap_len();
      end
      out_stall <= (rx_wait != 0);
    end
  end

  always @(posedge clk) begin : monitor
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_results.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("result %0d: none expected, got rsp %0d motor %0d valve %0d mode %0d",
                   results_seen, out_data.response, out_data.motor_drive,
                   out_data.valve_open, out_data.mode);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        if (out_data.response !== want.response || out_data.motor_drive !== want.motor_drive ||
            out_data.valve_open !== want.valve_open || out_data.mode !== want.mode) begin
          if (mismatches < REPORT_MAX) begin
            $write("result %0d: expected rsp %0d motor %0d valve %0d mode %0d,",
                   results_seen, want.response, want.motor_drive, want.valve_open,
                   want.mode);
            $display(" got rsp %0d motor %0d valve %0d mode %0d",
                     out_data.response, out_data.motor_drive,
                     out_data.valve_open, out_data.mode);
          end
          mismatches++;
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("** sampler_actuator_sequencer_unit: FAILED **");
      $finish;
    end
  end

  function automatic in_t mk(input cmd_t c, input logic tk, input logic ini, input logic fin,
                             input logic line);
    in_t v;
    v.command        = c;
    v.tick_elapsed   = tk;
    v.initial_switch = ini;
    v.final_switch   = fin;
    v.sensor_line    = line;
    return v;
  endfunction

  // one pass inside a running sequence; kind 0 sampling, 1 discharge, 2 arming
  function automatic in_t busy_pass(input int kind);
    int   r;
    cmd_t c;
    r = $urandom_range(0, 99);
    if (r < 70) c = CMD_NONE;
    else if (r < 80) c = r[0] ? CMD_ECHO : CMD_QUERY;
    else c = cmd_t'($urandom_range(0, 7));
    return mk(c, $urandom_range(0, 99) < 70, $urandom_range(0, 99) < (kind == 2 ? 12 : 30),
              $urandom_range(0, 99) < (kind == 0 ? 12 : 30), $urandom_range(0, 99) < 12);
  endfunction

  task automatic push_sequence(input int seq_max, output int n);
    int   kind;
    int   len;
    cmd_t c;
    kind = $urandom_range(0, 2);
    case (kind)
      0: c = CMD_SAMPLE;
      1: c = CMD_DISCHG;
      default: c = CMD_ARM;
    endcase
    pending_passes.push_back(mk(c, 1'($urandom), 1'($urandom), 1'($urandom),
                                $urandom_range(0, 3) == 0));
    len = $urandom_range(3, seq_max);
    for (int i = 0; i < len; i++) pending_passes.push_back(busy_pass(kind));
    n = len + 1;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  // every pass taken and answered, plus a little slack for the pipeline
  task automatic drain();
    do @(negedge clk);
    while (pending_passes.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [15:0] mt;
    logic [15:0] vt;
    logic [15:0] dt;
    logic [7:0]  dw;
    int          seq_max;
    int          pushed;
    int          n;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed passes at reset timings
    pending_passes.push_back(mk(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_ECHO, 1'b1, 1'b1, 1'b1, 1'b0));
    pending_passes.push_back(mk(CMD_QUERY, 1'b0, 1'b1, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_QUERY, 1'b1, 1'b0, 1'b1, 1'b0));
    pending_passes.push_back(mk(CMD_RESERVED, 1'b0, 1'b0, 1'b0, 1'b1));
    pending_passes.push_back(mk(CMD_ECHO, 1'b0, 1'b0, 1'b0, 1'b1));   // line held over the ping
    pending_passes.push_back(mk(CMD_UNKNOWN, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_SAMPLE, 1'b1, 1'b0, 1'b0, 1'b1)); // forwarded leaving idle
    pending_passes.push_back(mk(CMD_NONE, 1'b1, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_DISCHG, 1'b1, 1'b0, 1'b0, 1'b1)); // dropped while busy
    pending_passes.push_back(mk(CMD_NONE, 1'b0, 1'b0, 1'b1, 1'b0));   // final switch drops line
    pending_passes.push_back(mk(CMD_ARM, 1'b1, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b1));
    pending_passes.push_back(mk(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_ARM, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_NONE, 1'b1, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_QUERY, 1'b1, 1'b1, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_NONE, 1'b0, 1'b1, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    drain();

    // zero timings: every limit expires at once, valve never opened by discharge
    write_reg(CFG_MOTOR_TIMEOUT, 16'd0);
    write_reg(CFG_VALVE_TIMEOUT, 16'd0);
    write_reg(CFG_DISCHG_TIME, 16'd0);
    write_reg(CFG_DISCHG_WINDOW, 16'hff00);
    @(negedge clk);
    pending_passes.push_back(mk(CMD_DISCHG, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_ARM, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_passes.push_back(mk(CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0));
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          mt = 16'hffff;
          vt = 16'hffff;
          dt = 16'hffff;
          dw = 8'hff;
          seq_max = 40;
        end
        1: begin
          // wide open window against a short discharge
          mt = 16'd300;
          vt = 16'd300;
          dt = 16'($urandom_range(0, 300));
          dw = 8'hff;
          seq_max = 350;
        end
        default: begin
          mt = 16'($urandom_range(0, 25));
          vt = 16'($urandom_range(0, 25));
          dt = 16'($urandom_range(0, 30));
          dw = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 12));
          seq_max = 40;
        end
      endcase
      write_reg(CFG_MOTOR_TIMEOUT, mt);
      write_reg(CFG_VALVE_TIMEOUT, vt);
      write_reg(CFG_DISCHG_TIME, dt);
      write_reg(CFG_DISCHG_WINDOW, {8'($urandom), dw});
      @(negedge clk);
      tx_idle_en = !(ph % 4 == 1 || ph == 6);
      rx_idle_en = !(ph % 4 == 2 || ph == 6);
      pushed = 0;
      while (pushed < 150) begin
        if ($urandom_range(0, 4) == 0) begin
          pending_passes.push_back(in_t'(7'($urandom)));
          pushed++;
        end else begin
          push_sequence(seq_max, n);
          pushed += n;
        end
      end
      // receiver sits on its hands while passes keep coming
      if (ph == 3) long_hold_req++;
      drain();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("** sampler_actuator_sequencer_unit: PASSED **");
    end else begin
      $display("** sampler_actuator_sequencer_unit: FAILED **");
    end
    $finish;
  end

endmodule
